FILE: rtl/bpa_pkg.sv
`default_nettype none
package bpa_pkg;

    localparam int DEF_PAGES  = 2048;
    localparam int DEF_ORDERS = 9;

    localparam int CMD_W  = 1;
    localparam int ORD_W  = 4;
    localparam int PAGE_W = 11;
    localparam int STAT_W = 2;

    localparam logic [ORD_W-1:0] NOT_HEAD = 4'hF;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NOBLK   = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_BADFREE = 2'd2;

    // one table entry: allocated mark above the head order
    typedef struct packed {
        logic             alloc;
        logic [ORD_W-1:0] ord;
    } entry_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_SPLIT,
        S_FCHK,
        S_FEVAL,
        S_MRD,
        S_MEV,
        S_MWR,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

FILE: rtl/bpa_if.sv
`default_nettype none
interface bpa_in_if;
    logic                        valid;
    logic                        ready;
    logic [bpa_pkg::CMD_W-1:0]   command;
    logic [bpa_pkg::ORD_W-1:0]   block_order;
    logic [bpa_pkg::PAGE_W-1:0]  page_index;

    modport source (output valid, command, block_order, page_index, input ready);
    modport sink   (input valid, command, block_order, page_index, output ready);
endinterface

interface bpa_out_if;
    logic                        valid;
    logic                        ready;
    logic [bpa_pkg::STAT_W-1:0]  status;
    logic [bpa_pkg::PAGE_W-1:0]  result_page;
    logic [bpa_pkg::ORD_W-1:0]   result_order;

    modport source (output valid, status, result_page, result_order, input ready);
    modport sink   (input valid, status, result_page, result_order, output ready);
endinterface
`default_nettype wire

FILE: rtl/bpa_mem.sv
`default_nettype none
module bpa_mem #(
    parameter int PAGES = bpa_pkg::DEF_PAGES,
    localparam int AW   = $clog2(PAGES)
) (
    input  wire logic            clk,
    input  wire logic            we,
    input  wire logic [AW-1:0]   waddr,
    input  wire bpa_pkg::entry_t wdata,
    input  wire logic            re,
    input  wire logic [AW-1:0]   raddr,
    output bpa_pkg::entry_t      rdata
);

    bpa_pkg::entry_t mem [PAGES];
    bpa_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: rtl/buddy_page_allocator.sv
`default_nettype none
// Buddy page allocator over PAGES pages, block orders 0 to ORDERS-1. Block
// state (head order and allocated mark per page) lives in one table with a
// read and a write port, walked by a small sequencer. After reset a clearing
// pass writes every entry and loads the initial free blocks; no item is
// taken meanwhile. An allocate does one full scan of the table, one read per
// cycle, keeping the lowest free head of the smallest fitting order, then
// one write per split level and one for the allocated mark. A free reads,
// checks and clears its block's entry, then per merge level reads the buddy,
// clears the upper head and writes the merged head. One item is in flight at
// a time; the result waits in an output register until taken, and the next
// item can be taken in the cycle after that.
module buddy_page_allocator #(
    parameter int PAGES  = bpa_pkg::DEF_PAGES,
    parameter int ORDERS = bpa_pkg::DEF_ORDERS
) (
    input wire logic  clk,
    input wire logic  rst_n,
    bpa_in_if.sink    in,
    bpa_out_if.source out
);

    localparam int AW   = $clog2(PAGES);
    localparam int CW   = AW + 1;
    localparam int OW   = bpa_pkg::ORD_W;
    localparam int TOP  = ORDERS - 1;
    localparam int GRP  = 1 << TOP;
    localparam int FULL = (PAGES / GRP) * GRP;

    localparam logic [OW-1:0] TOP_O   = OW'(TOP);
    localparam logic [CW-1:0] PAGES_C = CW'(PAGES);
    localparam logic [CW-1:0] FULL_C  = CW'(FULL);
    localparam logic [CW-1:0] GMASK_C = CW'(GRP - 1);

    bpa_pkg::state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] raddr_reg, raddr_next;
    logic [OW-1:0] ord_reg, ord_next;
    logic [AW-1:0] page_reg, page_next;
    logic          found_reg, found_next;
    logic [OW-1:0] best_reg, best_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [OW-1:0] lvl_reg, lvl_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [OW-1:0] k_reg, k_next;
    logic [bpa_pkg::STAT_W-1:0] stat_reg, stat_next;
    logic [bpa_pkg::PAGE_W-1:0] rpage_reg, rpage_next;
    logic [OW-1:0] rord_reg, rord_next;

    logic            we, re;
    logic [AW-1:0]   waddr, maddr;
    bpa_pkg::entry_t wdata, rdata;
    logic            acc;
    logic            pg_bad;
    logic [CW-1:0]   bud;
    logic [AW-1:0]   bud_a;

    bpa_mem #(.PAGES(PAGES)) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (maddr),
        .rdata (rdata)
    );

    assign acc    = in.valid && in.ready;
    assign pg_bad = (32'(in.page_index) >= 32'(PAGES));
    assign bud    = {1'b0, cur_reg} ^ (CW'(1) << k_reg);
    assign bud_a  = bud[AW-1:0];

    assign in.ready         = (state_reg == bpa_pkg::S_IDLE);
    assign out.valid        = (state_reg == bpa_pkg::S_DONE);
    assign out.status       = stat_reg;
    assign out.result_page  = rpage_reg;
    assign out.result_order = rord_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bpa_pkg::S_CLEAR;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raddr_reg <= raddr_next;
        ord_reg   <= ord_next;
        page_reg  <= page_next;
        found_reg <= found_next;
        best_reg  <= best_next;
        addr_reg  <= addr_next;
        lvl_reg   <= lvl_next;
        cur_reg   <= cur_next;
        k_reg     <= k_next;
        stat_reg  <= stat_next;
        rpage_reg <= rpage_next;
        rord_reg  <= rord_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bpa_pkg::S_CLEAR:
                if (cnt_reg == PAGES_C - CW'(1)) state_next = bpa_pkg::S_IDLE;
            bpa_pkg::S_IDLE:
                if (acc)
                begin
                    if (in.block_order > TOP_O)
                        state_next = bpa_pkg::S_DONE;
                    else if (in.command == bpa_pkg::CMD_ALLOC)
                        state_next = bpa_pkg::S_SCAN;
                    else if (pg_bad)
                        state_next = bpa_pkg::S_DONE;
                    else
                        state_next = bpa_pkg::S_FCHK;
                end
            bpa_pkg::S_SCAN:
                if (cnt_reg == PAGES_C && !pend_reg)
                    state_next = found_reg ? bpa_pkg::S_SPLIT : bpa_pkg::S_DONE;
            bpa_pkg::S_SPLIT:
                if (lvl_reg == ord_reg) state_next = bpa_pkg::S_DONE;
            bpa_pkg::S_FCHK:
                state_next = bpa_pkg::S_FEVAL;
            bpa_pkg::S_FEVAL:
                state_next = (rdata.alloc && rdata.ord == ord_reg) ?
                             bpa_pkg::S_MRD : bpa_pkg::S_DONE;
            bpa_pkg::S_MRD:
                state_next = (k_reg >= TOP_O || bud >= PAGES_C) ?
                             bpa_pkg::S_DONE : bpa_pkg::S_MEV;
            bpa_pkg::S_MEV:
                state_next = (!rdata.alloc && rdata.ord == k_reg) ?
                             bpa_pkg::S_MWR : bpa_pkg::S_DONE;
            bpa_pkg::S_MWR:
                state_next = bpa_pkg::S_MRD;
            bpa_pkg::S_DONE:
                if (out.ready) state_next = bpa_pkg::S_IDLE;
            default:
                state_next = bpa_pkg::S_IDLE;
        endcase
    end

    // datapath and table access
    always_comb
    begin
        cnt_next   = cnt_reg;
        pend_next  = 1'b0;
        raddr_next = raddr_reg;
        ord_next   = ord_reg;
        page_next  = page_reg;
        found_next = found_reg;
        best_next  = best_reg;
        addr_next  = addr_reg;
        lvl_next   = lvl_reg;
        cur_next   = cur_reg;
        k_next     = k_reg;
        stat_next  = stat_reg;
        rpage_next = rpage_reg;
        rord_next  = rord_reg;
        we         = 1'b0;
        waddr      = addr_reg;
        wdata      = '{alloc: 1'b0, ord: '0};
        re         = 1'b0;
        maddr      = cnt_reg[AW-1:0];
        case (state_reg)
            bpa_pkg::S_CLEAR:
            begin
                we    = 1'b1;
                waddr = cnt_reg[AW-1:0];
                if (cnt_reg < FULL_C)
                    wdata.ord = ((cnt_reg & GMASK_C) == '0) ? TOP_O : bpa_pkg::NOT_HEAD;
                cnt_next = cnt_reg + CW'(1);
            end
            bpa_pkg::S_IDLE:
            begin
                cnt_next   = '0;
                found_next = 1'b0;
                stat_next  = bpa_pkg::STATUS_OK;
                rpage_next = '0;
                rord_next  = '0;
                if (acc)
                begin
                    ord_next  = in.block_order;
                    page_next = AW'(in.page_index);
                    if (in.block_order > TOP_O)
                        stat_next = (in.command == bpa_pkg::CMD_ALLOC) ?
                                    bpa_pkg::STATUS_NOBLK : bpa_pkg::STATUS_BADFREE;
                    else if (in.command == bpa_pkg::CMD_FREE && pg_bad)
                        stat_next = bpa_pkg::STATUS_BADFREE;
                end
            end
            bpa_pkg::S_SCAN:
            begin
                if (cnt_reg < PAGES_C)
                begin
                    re         = 1'b1;
                    pend_next  = 1'b1;
                    raddr_next = cnt_reg[AW-1:0];
                    cnt_next   = cnt_reg + CW'(1);
                end
                // keep the first free head found at the smallest order
                if (pend_reg && !rdata.alloc && rdata.ord >= ord_reg
                    && rdata.ord <= TOP_O && (!found_reg || rdata.ord < best_reg))
                begin
                    found_next = 1'b1;
                    best_next  = rdata.ord;
                    addr_next  = raddr_reg;
                end
                if (cnt_reg == PAGES_C && !pend_reg)
                begin
                    lvl_next = best_reg;
                    if (!found_reg) stat_next = bpa_pkg::STATUS_NOBLK;
                end
            end
            bpa_pkg::S_SPLIT:
            begin
                we    = 1'b1;
                waddr = addr_reg;
                if (lvl_reg != ord_reg)
                begin
                    wdata.ord = lvl_reg - OW'(1);
                    addr_next = addr_reg + (AW'(1) << (lvl_reg - OW'(1)));
                    lvl_next  = lvl_reg - OW'(1);
                end
                else
                begin
                    wdata      = '{alloc: 1'b1, ord: ord_reg};
                    rpage_next = bpa_pkg::PAGE_W'(addr_reg);
                    rord_next  = ord_reg;
                end
            end
            bpa_pkg::S_FCHK:
            begin
                re    = 1'b1;
                maddr = page_reg;
            end
            bpa_pkg::S_FEVAL:
            begin
                if (rdata.alloc && rdata.ord == ord_reg)
                begin
                    we        = 1'b1;
                    waddr     = page_reg;
                    wdata.ord = ord_reg;
                    cur_next  = page_reg;
                    k_next    = ord_reg;
                end
                else
                begin
                    stat_next = bpa_pkg::STATUS_BADFREE;
                end
            end
            bpa_pkg::S_MRD:
            begin
                if (k_reg >= TOP_O || bud >= PAGES_C)
                begin
                    rpage_next = bpa_pkg::PAGE_W'(cur_reg);
                    rord_next  = k_reg;
                end
                else
                begin
                    re         = 1'b1;
                    maddr      = bud_a;
                    raddr_next = bud_a;
                end
            end
            bpa_pkg::S_MEV:
            begin
                if (!rdata.alloc && rdata.ord == k_reg)
                begin
                    // upper of the pair stops being a head
                    we        = 1'b1;
                    waddr     = (raddr_reg > cur_reg) ? raddr_reg : cur_reg;
                    wdata.ord = bpa_pkg::NOT_HEAD;
                    cur_next  = (raddr_reg < cur_reg) ? raddr_reg : cur_reg;
                    k_next    = k_reg + OW'(1);
                end
                else
                begin
                    rpage_next = bpa_pkg::PAGE_W'(cur_reg);
                    rord_next  = k_reg;
                end
            end
            bpa_pkg::S_MWR:
            begin
                we        = 1'b1;
                waddr     = cur_reg;
                wdata.ord = k_reg;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: verif/buddy_page_allocator_tb.sv
module tb;

    localparam int NPAGES      = bpa_pkg::DEF_PAGES;
    localparam int TOP         = bpa_pkg::DEF_ORDERS - 1;
    localparam int N_RANDOM    = 600;
    localparam int IDLE_LIMIT  = 40000;
    localparam int HOLD_CYCLES = 3 * NPAGES;

    typedef struct packed {
        logic [bpa_pkg::STAT_W-1:0] status;
        logic [bpa_pkg::PAGE_W-1:0] page;
        logic [bpa_pkg::ORD_W-1:0]  order;
    } alloc_result_t;

    class alloc_scoreboard;
        logic [bpa_pkg::ORD_W-1:0] head_ord[NPAGES];
        bit               in_use[NPAGES];
        alloc_result_t    pending[$];
        int               errors;
        int               checked;
        int               n_ok;
        int               n_nofit;
        int               n_badfree;
        int               n_merges;

        function void clear_table();
            int i;
            int full;
            full = NPAGES & ~((1 << TOP) - 1);
            for (i = 0; i < NPAGES; i++)
            begin
                in_use[i] = 0;
                if (i < full)
                    head_ord[i] = ((i % (1 << TOP)) == 0) ?
                                  bpa_pkg::ORD_W'(TOP) : bpa_pkg::NOT_HEAD;
                else
                    head_ord[i] = '0;
            end
        endfunction

        function bit free_head(int p, int k);
            return p < NPAGES && head_ord[p] == k && !in_use[p];
        endfunction

        function void accept(logic [bpa_pkg::CMD_W-1:0] cmd,
                             logic [bpa_pkg::ORD_W-1:0] ord,
                             logic [bpa_pkg::PAGE_W-1:0] pg);
            alloc_result_t r;
            int k;
            int p;
            int addr;
            int cur;
            int bud;
            bit hit;
            r = '0;
            r.status = bpa_pkg::STATUS_OK;
            if (cmd == bpa_pkg::CMD_ALLOC)
            begin
                hit = 0;
                addr = 0;
                if (ord <= TOP)
                begin
                    for (k = ord; k <= TOP && !hit; k++)
                        for (p = 0; p < NPAGES && !hit; p++)
                            if (free_head(p, k))
                            begin
                                hit = 1;
                                addr = p;
                                cur = k;
                            end
                end
                if (!hit)
                    r.status = bpa_pkg::STATUS_NOBLK;
                else
                begin
                    for (k = cur; k > ord; k--)
                    begin
                        head_ord[addr] = bpa_pkg::ORD_W'(k - 1);
                        addr += 1 << (k - 1);
                    end
                    head_ord[addr] = ord;
                    in_use[addr] = 1;
                    r.page = bpa_pkg::PAGE_W'(addr);
                    r.order = ord;
                end
            end
            else if (pg >= NPAGES || !in_use[pg] || head_ord[pg] != ord || ord > TOP)
                r.status = bpa_pkg::STATUS_BADFREE;
            else
            begin
                in_use[pg] = 0;
                cur = pg;
                k = ord;
                while (k < TOP)
                begin
                    bud = cur ^ (1 << k);
                    if (!free_head(bud, k))
                        break;
                    if (bud < cur)
                    begin
                        head_ord[cur] = bpa_pkg::NOT_HEAD;
                        cur = bud;
                    end
                    else
                        head_ord[bud] = bpa_pkg::NOT_HEAD;
                    k++;
                    head_ord[cur] = bpa_pkg::ORD_W'(k);
                    n_merges++;
                end
                r.page = bpa_pkg::PAGE_W'(cur);
                r.order = bpa_pkg::ORD_W'(k);
            end
            pending.push_back(r);
        endfunction

        task check(alloc_result_t got);
            alloc_result_t exp_r;
            if (pending.size() == 0)
            begin
                report_mismatch("result with nothing pending", got, got);
                return;
            end
            exp_r = pending.pop_front();
            checked++;
            case (got.status)
                bpa_pkg::STATUS_OK:      n_ok++;
                bpa_pkg::STATUS_NOBLK:   n_nofit++;
                bpa_pkg::STATUS_BADFREE: n_badfree++;
                default:                 ;
            endcase
            if (got.status != exp_r.status)
                report_mismatch("status", got, exp_r);
            if (got.page != exp_r.page)
                report_mismatch("result_page", got, exp_r);
            if (got.order != exp_r.order)
                report_mismatch("result_order", got, exp_r);
        endtask

        task report_mismatch(string what, alloc_result_t got, alloc_result_t want);
            errors++;
            if (errors <= 30)
                $display("ERROR %s: got st=%0d pg=%0d ord=%0d want st=%0d pg=%0d ord=%0d",
                         what, got.status, got.page, got.order,
                         want.status, want.page, want.order);
        endtask
    endclass

    logic clk;
    logic rst_n;
    bpa_in_if  req_if ();
    bpa_out_if rsp_if ();

    buddy_page_allocator DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (req_if.sink),
        .out   (rsp_if.source)
    );

    alloc_scoreboard sb;
    bit    hold_off;
    bit    stim_done;
    int    idle_cycles = 0;
    int    sent;
    logic [bpa_pkg::PAGE_W-1:0] live_pages[$];
    logic [bpa_pkg::ORD_W-1:0]  live_orders[$];
    bit    last_was_free[$];

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    function int short_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 60);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    // track allocated blocks so most frees hit real blocks
    always @(posedge clk)
    begin
        bit was_free;
        if (rsp_if.valid && rsp_if.ready)
        begin
            sb.check({rsp_if.status, rsp_if.result_page, rsp_if.result_order});
            was_free = last_was_free.pop_front();
            // allocations produce blocks; frees are removed at send time
            if (rsp_if.status == bpa_pkg::STATUS_OK && !was_free)
            begin
                live_pages.push_back(rsp_if.result_page);
                live_orders.push_back(rsp_if.result_order);
            end
        end
    end

    task automatic send(logic [bpa_pkg::CMD_W-1:0] cmd, logic [bpa_pkg::ORD_W-1:0] ord,
                        logic [bpa_pkg::PAGE_W-1:0] pg, bit gaps);
        int g;
        g = gaps ? short_gap() : 0;
        if (g > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.command     <= cmd;
        req_if.block_order <= ord;
        req_if.page_index  <= pg;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        sb.accept(cmd, ord, pg);
        last_was_free.push_back(cmd == bpa_pkg::CMD_FREE);
        sent++;
    endtask

    task automatic wait_drain();
        req_if.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random();
        int i;
        int r;
        logic [bpa_pkg::PAGE_W-1:0] pg;
        logic [bpa_pkg::ORD_W-1:0]  ord;
        r = $urandom_range(0, 99);
        if (r < 50)
            send(bpa_pkg::CMD_ALLOC, ($urandom_range(0, 9) == 0) ?
                 bpa_pkg::ORD_W'($urandom) : bpa_pkg::ORD_W'($urandom_range(0, 3)),
                 bpa_pkg::PAGE_W'($urandom), 1);
        else if (r < 85 && live_pages.size() != 0)
        begin
            i = $urandom_range(0, live_pages.size() - 1);
            pg = live_pages[i];
            ord = live_orders[i];
            live_pages.delete(i);
            live_orders.delete(i);
            send(bpa_pkg::CMD_FREE, ord, pg, 1);
        end
        else
            send(bpa_pkg::CMD_FREE, bpa_pkg::ORD_W'($urandom),
                 bpa_pkg::PAGE_W'($urandom), 1);
    endtask

    // output side: random stalls, plus one long hold-off
    initial
    begin
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 0;
            end
            else if (stim_done || sent < 40)
                rsp_if.ready <= 1'b1;
            else
                rsp_if.ready <= (short_gap() == 0);
        end
    end

    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("timeout");
            $display("buddy_page_allocator: mismatch");
            $finish;
        end
    end

    initial
    begin
        int i;
        int p;
        sb = new();
        sb.clear_table();
        req_if.valid = 1'b0;
        req_if.command = bpa_pkg::CMD_ALLOC;
        req_if.block_order = '0;
        req_if.page_index = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        // directed: extremes, bad frees, exhaust top order, free top-order blocks back
        send(bpa_pkg::CMD_ALLOC, bpa_pkg::ORD_W'(TOP), '0, 0);
        send(bpa_pkg::CMD_ALLOC, 4'd0, '0, 0);
        send(bpa_pkg::CMD_ALLOC, 4'd9, '0, 0);
        send(bpa_pkg::CMD_ALLOC, 4'hF, 11'h7FF, 0);
        send(bpa_pkg::CMD_FREE, 4'd0, 11'h7FF, 0);
        send(bpa_pkg::CMD_FREE, 4'd0, 11'd0, 0);
        send(bpa_pkg::CMD_FREE, bpa_pkg::ORD_W'(TOP), 11'h700, 0);
        send(bpa_pkg::CMD_FREE, 4'hF, 11'h700, 0);
        send(bpa_pkg::CMD_FREE, 4'd0, 11'h6FF, 0);
        send(bpa_pkg::CMD_FREE, bpa_pkg::ORD_W'(TOP), 11'h700, 0);
        send(bpa_pkg::CMD_FREE, bpa_pkg::ORD_W'(TOP), 11'h700, 0);
        for (i = 0; i < 9; i++)
            send(bpa_pkg::CMD_ALLOC, bpa_pkg::ORD_W'(TOP), '0, 0);
        for (i = 0; i < 8; i++)
        begin
            p = 2047 - 256 * i - 255;
            send(bpa_pkg::CMD_FREE, bpa_pkg::ORD_W'(TOP), bpa_pkg::PAGE_W'(p), 0);
        end
        wait_drain();
        // long receiver hold-off while the sender keeps offering
        hold_off = 1;
        for (i = 0; i < 6; i++)
            send_random();
        wait_drain();
        for (i = 0; i < N_RANDOM; i++)
        begin
            send_random();
            if (i == N_RANDOM / 2)
                wait_drain();
        end
        stim_done = 1;
        wait_drain();
        repeat (NPAGES + 200) @(posedge clk);
        $display("covered %0d items: %0d ok, %0d no block, %0d bad free, %0d merge steps",
                 sent, sb.n_ok, sb.n_nofit, sb.n_badfree, sb.n_merges);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("buddy_page_allocator: match");
        else
            $display("buddy_page_allocator: mismatch");
        $finish;
    end
endmodule

FILE: buddy_page_allocator.f
rtl/bpa_pkg.sv
rtl/bpa_if.sv
rtl/bpa_mem.sv
rtl/buddy_page_allocator.sv
verif/buddy_page_allocator_tb.sv
